>>> rtl/core/wsu_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Word shift unit package
// Operation codes, field widths and condition codes shared by the shift unit.
// ============================================================================
package wsu_pkg;

  localparam int DATA_W = 32;  // register and result width
  localparam int IDX_W  = 5;   // width of a register index field
  localparam int AMT_W  = 6;   // significant bits of a register shift amount
  localparam int SH_W   = 5;   // width of a rotate or immediate shift count
  localparam int CR_W   = 4;   // condition field width
  localparam int ACT_W  = 3;   // operation code width

  typedef enum logic [ACT_W-1:0] {
    ACT_SLW   = 3'd0,
    ACT_SRW   = 3'd1,
    ACT_SRAW  = 3'd2,
    ACT_SRAWI = 3'd3,
    ACT_WRITE = 3'd4
  } action_t;

  // Condition field: less, greater, equal, summary overflow.
  localparam logic [CR_W-2:0] CR_LT = 3'b100;
  localparam logic [CR_W-2:0] CR_GT = 3'b010;
  localparam logic [CR_W-2:0] CR_EQ = 3'b001;

endpackage

>>> rtl/core/wsu_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// Word shift unit RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module wsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-before-write: a read at the address being written returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/word_shift_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// Word shift unit
// 32-bit shift execution unit (shift left/right word, shift right algebraic by
// register or immediate, register write) with its own register file, carry and condition.
// ============================================================================
// The unit accepts one transaction per clock cycle while the input is not
// stalled, and returns one result transaction for each valid operation; codes
// 5 to 7 are accepted and dropped without effect. The register file sits in
// two copies of a synchronous RAM, one read for the source operand and one for
// the shift amount, both written with every result. A transaction reads the
// RAMs on the cycle it is accepted, computes and writes back in the following
// execute stage, and lands in the output register. A result written back in
// the very cycle a following transaction reads the same register is forwarded,
// so back-to-back dependent instructions run at full rate. The execute stage
// holds only while the output register is full and stalled, and the input
// stalls with it; throughput is then set by the consumer alone. Registers must
// be written before they are read, and register indices are taken modulo
// REG_COUNT.
module word_shift_unit #(
  parameter int REG_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [4:0]  in_src_reg,
  input  logic [4:0]  in_dst_reg,
  input  logic [4:0]  in_amount_reg,
  input  logic [4:0]  in_shift_imm,
  input  logic        in_record,
  input  logic        in_summary_overflow,
  input  logic [31:0] in_write_value,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_value,
  output logic [4:0]  out_dest_index,
  output logic        out_carry_out,
  output logic [3:0]  out_cond_field,
  output logic        out_cond_written
);

  localparam int AW    = $clog2(REG_COUNT);
  localparam int IW    = wsu_pkg::IDX_W;
  localparam int DW    = wsu_pkg::DATA_W;
  localparam int NIDX  = 2 ** IW;

  // Index wrapping table: entry i holds i modulo REG_COUNT.
  logic [IW-1:0] wrap_lut [NIDX];

  for (genvar g = 0; g < NIDX; g++) begin : g_wrap
    assign wrap_lut[g] = IW'(g % REG_COUNT);
  end

  // The wrapped index is below REG_COUNT, so it always fits the address width.
  function automatic logic [AW-1:0] to_addr(input logic [IW-1:0] idx);
    logic [IW+AW-1:0] ext;
    ext = {{AW{1'b0}}, idx};
    return ext[AW-1:0];
  endfunction

  function automatic logic [IW-1:0] to_idx(input logic [AW-1:0] addr);
    logic [IW+AW-1:0] ext;
    ext = {{IW{1'b0}}, addr};
    return ext[IW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Handshake and pipeline control
  // --------------------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s1_adv;
  logic in_accept;
  logic in_known;

  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    case (wsu_pkg::action_t'(in_action))
      wsu_pkg::ACT_SLW, wsu_pkg::ACT_SRW, wsu_pkg::ACT_SRAW,
      wsu_pkg::ACT_SRAWI, wsu_pkg::ACT_WRITE: in_known = 1'b1;
      default:                                in_known = 1'b0;
    endcase
  end

  assign s1_valid_nxt  = (in_accept && in_known) || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  // --------------------------------------------------------------------------
  // Register file read
  // --------------------------------------------------------------------------
  logic [AW-1:0] rs_addr, rb_addr, ra_addr;

  assign rs_addr = to_addr(wrap_lut[in_src_reg]);
  assign rb_addr = to_addr(wrap_lut[in_amount_reg]);
  assign ra_addr = to_addr(wrap_lut[in_dst_reg]);

  logic [DW-1:0] src_q, amt_q;
  logic [AW-1:0] s1_ra_r;
  logic [DW-1:0] s1_res;

  wsu_ram #(.WIDTH(DW), .DEPTH(REG_COUNT)) u_src_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_ra_r),
    .wdata (s1_res),
    .re    (in_accept),
    .raddr (rs_addr),
    .rdata (src_q)
  );

  wsu_ram #(.WIDTH(DW), .DEPTH(REG_COUNT)) u_amt_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_ra_r),
    .wdata (s1_res),
    .re    (in_accept),
    .raddr (rb_addr),
    .rdata (amt_q)
  );

  // --------------------------------------------------------------------------
  // Execute stage registers
  // --------------------------------------------------------------------------
  wsu_pkg::action_t      s1_action_r;
  logic [wsu_pkg::SH_W-1:0] s1_shift_imm_r;
  logic                  s1_record_r;
  logic                  s1_so_r;
  logic [DW-1:0]         s1_wval_r;

  // Forwarding of the result written in the cycle the operands were read.
  logic                  fwd_src_hit_r;
  logic                  fwd_amt_hit_r;
  logic [DW-1:0]         fwd_data_r;

  // Architectural carry and condition field.
  logic                  carry_r, carry_nxt;
  logic [wsu_pkg::CR_W-1:0] cond_r, cond_nxt;
  logic                  cond_wr;

  // --------------------------------------------------------------------------
  // Execute: shifts, carry and condition field
  // --------------------------------------------------------------------------
  logic [DW-1:0]            src, amt_word;
  logic [wsu_pkg::AMT_W-1:0] amt6;
  logic [wsu_pkg::SH_W-1:0] sh_n;
  logic                     all_sign;
  logic [2*DW-1:0]          rot_wide;
  logic [DW-1:0]            rot, mask, fill, ar_res;
  logic                     ar_carry;

  always_comb begin
    src      = fwd_src_hit_r ? fwd_data_r : src_q;
    amt_word = fwd_amt_hit_r ? fwd_data_r : amt_q;
    amt6     = amt_word[wsu_pkg::AMT_W-1:0];

    // Algebraic shift as a rotate, then the vacated bits take the sign.
    sh_n     = (s1_action_r == wsu_pkg::ACT_SRAW) ? amt6[wsu_pkg::SH_W-1:0] : s1_shift_imm_r;
    all_sign = (s1_action_r == wsu_pkg::ACT_SRAW) && amt6[wsu_pkg::AMT_W-1];
    rot_wide = {src, src} >> sh_n;
    rot      = rot_wide[DW-1:0];
    mask     = all_sign ? '0 : ({DW{1'b1}} >> sh_n);
    fill     = {DW{src[DW-1]}};
    ar_res   = (rot & mask) | (fill & ~mask);
    ar_carry = src[DW-1] && ((rot & ~mask) != '0);

    carry_nxt = carry_r;
    case (s1_action_r)
      wsu_pkg::ACT_SLW: begin
        s1_res = amt6[wsu_pkg::AMT_W-1] ? '0 : (src << amt6[wsu_pkg::SH_W-1:0]);
      end
      wsu_pkg::ACT_SRW: begin
        s1_res = amt6[wsu_pkg::AMT_W-1] ? '0 : (src >> amt6[wsu_pkg::SH_W-1:0]);
      end
      wsu_pkg::ACT_SRAW, wsu_pkg::ACT_SRAWI: begin
        s1_res    = ar_res;
        carry_nxt = ar_carry;
      end
      default: begin
        s1_res = s1_wval_r;
      end
    endcase

    // A plain register write never touches the condition field.
    cond_wr  = s1_record_r && (s1_action_r != wsu_pkg::ACT_WRITE);
    cond_nxt = cond_r;
    if (cond_wr) begin
      if (s1_res == '0) begin
        cond_nxt = {wsu_pkg::CR_EQ, s1_so_r};
      end else if (s1_res[DW-1]) begin
        cond_nxt = {wsu_pkg::CR_LT, s1_so_r};
      end else begin
        cond_nxt = {wsu_pkg::CR_GT, s1_so_r};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Clocked state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      carry_r       <= 1'b0;
      cond_r        <= '0;
      fwd_src_hit_r <= 1'b0;
      fwd_amt_hit_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        carry_r <= carry_nxt;
        cond_r  <= cond_nxt;
      end
      if (in_accept) begin
        fwd_src_hit_r <= s1_adv && (s1_ra_r == rs_addr);
        fwd_amt_hit_r <= s1_adv && (s1_ra_r == rb_addr);
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action_r    <= wsu_pkg::action_t'(in_action);
      s1_ra_r        <= ra_addr;
      s1_shift_imm_r <= in_shift_imm;
      s1_record_r    <= in_record;
      s1_so_r        <= in_summary_overflow;
      s1_wval_r      <= in_write_value;
      fwd_data_r     <= s1_res;
    end
    if (s1_adv) begin
      out_result_value <= s1_res;
      out_dest_index   <= to_idx(s1_ra_r);
      out_carry_out    <= carry_nxt;
      out_cond_field   <= cond_nxt;
      out_cond_written <= cond_wr;
    end
  end

endmodule
